### rtl/priority_event_table_macros.svh
// Assertion shorthands used by the checker file of the event table.
`ifndef PRIORITY_EVENT_TABLE_MACROS_SVH
`define PRIORITY_EVENT_TABLE_MACROS_SVH

// Checked at every rising edge outside of reset.
`define PET_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pet: assertion failed");

// Checked at every rising edge, reset included.
`define PET_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("pet: assertion failed");

`endif

### rtl/pet_pkg.sv
package pet_pkg;

    // Field widths of one event.
    localparam int CODE_W   = 8;
    localparam int SRC_W    = 16;
    localparam int PRI_W    = 4;
    localparam int HANDLE_W = 32;
    localparam int LEN_W    = 16;
    localparam int PAY_W    = 32;
    localparam int IDX_W    = 4;

    // Stream word widths.
    localparam int IN_DATA_W  = 128;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 2;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Operation codes carried in the input tuser.
    typedef enum logic [IN_USER_W-1:0] {
        OP_POST      = 2'd0,
        OP_CLEAR     = 2'd1,
        OP_CLEAR_ALL = 2'd2,
        OP_GET       = 2'd3
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUNNING   = 1'b0,
        CFG_EMERGENCY = 1'b1
    } t_cfg_reg;

    // One slot of the event memory.
    typedef struct packed {
        logic [PAY_W-1:0]    payload;
        logic [LEN_W-1:0]    length;
        logic [HANDLE_W-1:0] handle;
        logic [PRI_W-1:0]    prio;
        logic [SRC_W-1:0]    source;
        logic [CODE_W-1:0]   code;
    } t_entry;

endpackage

### rtl/pet_slot_ram.sv
module pet_slot_ram
    import pet_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/priority_event_table.sv
// Event table with SLOTS slots kept in a single-port-read slot memory; a
// busy bit per slot in flip-flops marks the occupied slots and is cleared
// by reset. One operation is handled at a time. A post walks the busy
// bits one slot per cycle up to the lowest free slot and fails when the
// table is full. A get reads the slot memory one entry per cycle through
// its single read port until every slot is read or a match at or above
// the emergency level stops the scan; a get while not running skips the
// scan. A result waiting in the output register does not block the next
// input word; only the end of the next operation waits for it.
module priority_event_table
    import pet_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input word: tdata = event_code, source_bits, priority_req, param_handle,
    // param_length, payload, slot_index, source_mask (from bit 0 up).
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser = op.
    input  logic [IN_USER_W-1:0]  i_s_axis_tuser,
    // Result word: tdata = hit_slot, hit_code, hit_source, hit_priority,
    // hit_handle, hit_length, hit_payload (from bit 0 up).
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser = success, found.
    output logic [OUT_USER_W-1:0] o_m_axis_tuser,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POST,
        ST_GET,
        ST_EMIT
    } t_state;

    t_state                r_state;
    logic [SLOTS-1:0]      r_occ;
    logic                  r_running;
    logic [PRI_W-1:0]      r_emerg;
    logic [CW-1:0]         r_cnt;
    logic                  r_pend;
    logic [SW-1:0]         r_pidx;
    t_entry                r_req;
    logic [SRC_W-1:0]      r_mask;
    logic                  r_success;
    logic                  r_have;
    logic [SW-1:0]         r_best_idx;
    t_entry                r_best;
    logic                  r_m_tvalid;
    logic [OUT_DATA_W-1:0] r_m_tdata;
    logic [OUT_USER_W-1:0] r_m_tuser;

    // Input word fields.
    t_op              in_op;
    t_entry           in_entry;
    logic [IDX_W-1:0] in_slot_index;
    logic [SRC_W-1:0] in_mask;
    logic [XW-1:0]    clr_idx;
    logic             clr_ok;
    logic             in_accept;

    assign in_op            = t_op'(i_s_axis_tuser);
    assign in_entry.code    = i_s_axis_tdata[7:0];
    assign in_entry.source  = i_s_axis_tdata[23:8];
    assign in_entry.prio    = i_s_axis_tdata[27:24];
    assign in_entry.handle  = i_s_axis_tdata[59:28];
    assign in_entry.length  = i_s_axis_tdata[75:60];
    assign in_entry.payload = i_s_axis_tdata[107:76];
    assign in_slot_index    = i_s_axis_tdata[111:108];
    assign in_mask          = i_s_axis_tdata[127:112];
    assign clr_idx          = XW'(in_slot_index);
    assign clr_ok           = clr_idx < XW'(SLOTS);
    assign in_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Slot memory access.
    logic          scan_end;
    logic          post_free;
    logic          ram_we;
    logic [SW-1:0] ram_addr;
    t_entry        ram_rdata;

    assign scan_end  = r_cnt == CW'(SLOTS);
    assign ram_addr  = r_cnt[SW-1:0];
    assign post_free = !scan_end && !r_occ[ram_addr];
    assign ram_we    = (r_state == ST_POST) && post_free;

    pet_slot_ram #(
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (r_req),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    // Get scan: compare the entry read in the previous cycle with the best so far.
    logic match;
    logic stop;

    assign match = r_pend && r_occ[r_pidx] && ((ram_rdata.source & r_mask) != '0) &&
                   (!r_have || (ram_rdata.prio > r_best.prio));
    assign stop  = match && (ram_rdata.prio >= r_emerg);

    // Result word built from the result registers.
    t_entry        hit;
    logic [XW-1:0] hit_slot_x;

    assign hit        = r_have ? r_best : '0;
    assign hit_slot_x = XW'(r_best_idx);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_emerg   <= '1;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_RUNNING:   r_running <= i_cfg_wdata[0];
                CFG_EMERGENCY: r_emerg   <= i_cfg_wdata[PRI_W-1:0];
                default: ;
            endcase
        end
    end

    // Operation sequencer, busy bits and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_occ      <= '0;
            r_cnt      <= '0;
            r_pend     <= 1'b0;
            r_success  <= 1'b0;
            r_have     <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            // The emit state reloads the output register itself.
            if (r_m_tvalid && i_m_axis_tready && (r_state != ST_EMIT)) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_req      <= in_entry;
                        r_mask     <= in_mask;
                        r_cnt      <= '0;
                        r_pend     <= 1'b0;
                        r_success  <= 1'b1;
                        r_have     <= 1'b0;
                        r_best_idx <= '0;
                        case (in_op)
                            OP_POST: r_state <= ST_POST;
                            OP_CLEAR: begin
                                if (clr_ok) begin
                                    r_occ[clr_idx[SW-1:0]] <= 1'b0;
                                end
                                r_state <= ST_EMIT;
                            end
                            OP_CLEAR_ALL: begin
                                r_occ   <= '0;
                                r_state <= ST_EMIT;
                            end
                            OP_GET: r_state <= r_running ? ST_GET : ST_EMIT;
                            default: r_state <= ST_EMIT;
                        endcase
                    end
                end
                ST_POST: begin
                    // Walk the busy bits up to the lowest free slot.
                    if (scan_end) begin
                        r_success <= 1'b0;
                        r_state   <= ST_EMIT;
                    end else if (post_free) begin
                        r_occ[ram_addr] <= r_req.code != '0;
                        r_best_idx      <= ram_addr;
                        r_state         <= ST_EMIT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_GET: begin
                    // Issue one read per cycle while evaluating the previous one.
                    r_pend <= !scan_end;
                    r_pidx <= ram_addr;
                    if (!scan_end) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (match) begin
                        r_have     <= 1'b1;
                        r_best     <= ram_rdata;
                        r_best_idx <= r_pidx;
                    end
                    if (stop || (!r_pend && scan_end)) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // Load the output register once it is free.
                    if (!r_m_tvalid || i_m_axis_tready) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= {hit.payload, hit.length, hit.handle, hit.prio,
                                       hit.source, hit.code, hit_slot_x[IDX_W-1:0]};
                        r_m_tuser  <= {r_have, r_success};
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = r_state == ST_IDLE;
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

endmodule

### rtl/pet_checker.sv
`include "priority_event_table_macros.svh"

module pet_checker
    import pet_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [OUT_USER_W-1:0] o_m_axis_tuser
);

    // After reset the block is ready and shows no result word.
    `PET_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)

    // One operation at a time: an accepted word makes the block busy.
    `PET_ASSERT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)

    // A stalled result word holds.
    `PET_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // A found event always comes with success.
    `PET_ASSERT(a_found_success, o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tuser[0])

    // A failed post reports an all-zero word.
    `PET_ASSERT(a_fail_zero, o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)

endmodule

bind priority_event_table pet_checker u_pet_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

### verif/tb_priority_event_table.sv
module tb_priority_event_table;
    import pet_pkg::*;

    localparam int SLOTS        = 16;
    localparam int WATCHDOG_MAX = 4000;
    localparam int LONG_HOLD    = 500;
    localparam int SETTLE       = 2 * SLOTS + 8;

    // One input word, fields as the block sees them.
    typedef struct packed {
        t_op                 op;
        logic [CODE_W-1:0]   code;
        logic [SRC_W-1:0]    source;
        logic [PRI_W-1:0]    prio;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    length;
        logic [PAY_W-1:0]    payload;
        logic [IDX_W-1:0]    slot;
        logic [SRC_W-1:0]    mask;
    } t_item;

    // One result word, unpacked from tuser and tdata.
    typedef struct packed {
        logic                success;
        logic                found;
        logic [IDX_W-1:0]    slot;
        logic [CODE_W-1:0]   code;
        logic [SRC_W-1:0]    source;
        logic [PRI_W-1:0]    prio;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    length;
        logic [PAY_W-1:0]    payload;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // tdata: event_code, source_bits, priority_req, param_handle, param_length,
    // payload, slot_index, source_mask (from bit 0 up).
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    // tuser: op.
    logic [IN_USER_W-1:0]  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // tdata: hit_slot, hit_code, hit_source, hit_priority, hit_handle,
    // hit_length, hit_payload (from bit 0 up).
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    // tuser: success, found.
    logic [OUT_USER_W-1:0] o_m_axis_tuser;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // Mirror of the table and its registers, updated as words are accepted.
    t_entry            slot_mirror [SLOTS];
    logic              running_mirror;
    logic [PRI_W-1:0]  emergency_mirror;
    t_result           pending_results [$];

    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int unsigned burst_left     = 0;
    bit          gaps_on        = 1'b1;
    bit          long_hold_req  = 1'b0;

    priority_event_table #(
        .SLOTS(SLOTS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Applies one operation to the mirror and returns the word it should produce.
    function automatic t_result table_apply(input t_item it);
        t_result          r;
        bit               have;
        bit               stop;
        int               best;
        logic [PRI_W-1:0] best_pri;
        r        = '0;
        have     = 1'b0;
        stop     = 1'b0;
        best     = 0;
        best_pri = '0;
        case (it.op)
            OP_POST: begin
                // Lowest free slot takes the event; a zero code leaves it free.
                for (int i = 0; i < SLOTS; i++) begin
                    if (!stop && slot_mirror[i].code == '0) begin
                        slot_mirror[i].code    = it.code;
                        slot_mirror[i].source  = it.source;
                        slot_mirror[i].prio    = it.prio;
                        slot_mirror[i].handle  = it.handle;
                        slot_mirror[i].length  = it.length;
                        slot_mirror[i].payload = it.payload;
                        r.success = 1'b1;
                        r.slot    = i[IDX_W-1:0];
                        stop      = 1'b1;
                    end
                end
            end
            OP_CLEAR: begin
                if (int'(it.slot) < SLOTS) begin
                    slot_mirror[it.slot].code = '0;
                end
                r.success = 1'b1;
            end
            OP_CLEAR_ALL: begin
                for (int i = 0; i < SLOTS; i++) begin
                    slot_mirror[i].code = '0;
                end
                r.success = 1'b1;
            end
            default: begin
                // Highest priority among matching slots, lowest index on a tie,
                // stopping early once a match reaches the emergency level.
                r.success = 1'b1;
                if (running_mirror) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!stop && slot_mirror[i].code != '0 &&
                            (slot_mirror[i].source & it.mask) != '0 &&
                            (!have || slot_mirror[i].prio > best_pri)) begin
                            have     = 1'b1;
                            best     = i;
                            best_pri = slot_mirror[i].prio;
                            if (best_pri >= emergency_mirror) begin
                                stop = 1'b1;
                            end
                        end
                    end
                end
                if (have) begin
                    r.found   = 1'b1;
                    r.slot    = best[IDX_W-1:0];
                    r.code    = slot_mirror[best].code;
                    r.source  = slot_mirror[best].source;
                    r.prio    = slot_mirror[best].prio;
                    r.handle  = slot_mirror[best].handle;
                    r.length  = slot_mirror[best].length;
                    r.payload = slot_mirror[best].payload;
                end
            end
        endcase
        return r;
    endfunction

    // Source and mask patterns: single bits, dense, sparse, empty and full.
    function automatic logic [SRC_W-1:0] random_sources();
        logic [SRC_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = 16'h0001 << $urandom_range(0, 15);
            1: v = 16'($urandom);
            2: v = ~(16'h0001 << $urandom_range(0, 15));
            3: v = 16'($urandom & $urandom & $urandom);
            default: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        return v;
    endfunction

    function automatic t_item random_item(input int post_pct, input int pri_top);
        t_item       it;
        int unsigned pick;
        it.code    = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        it.source  = random_sources();
        it.prio    = 4'($urandom_range(0, pri_top));
        it.handle  = $urandom;
        it.length  = 16'($urandom);
        it.payload = $urandom;
        it.slot    = 4'($urandom);
        it.mask    = random_sources();
        pick       = $urandom_range(0, 99);
        if (pick < post_pct) begin
            it.op = OP_POST;
        end else if (pick >= 98) begin
            it.op = OP_CLEAR_ALL;
        end else if ($urandom_range(0, 2) == 0) begin
            it.op = OP_CLEAR;
        end else begin
            it.op = OP_GET;
        end
        return it;
    endfunction

    function automatic t_item post_item(input logic [CODE_W-1:0] code,
                                        input logic [SRC_W-1:0] source,
                                        input logic [PRI_W-1:0] prio);
        t_item it;
        it         = random_item(0, 15);
        it.op      = OP_POST;
        it.code    = code;
        it.source  = source;
        it.prio    = prio;
        return it;
    endfunction

    function automatic t_item control_item(input t_op op, input logic [IDX_W-1:0] slot,
                                           input logic [SRC_W-1:0] mask);
        t_item it;
        it      = random_item(0, 15);
        it.op   = op;
        it.slot = slot;
        it.mask = mask;
        return it;
    endfunction

    // Offers one word, with random gaps between bursts, and records its result.
    task automatic send_item(input t_item it);
        int unsigned gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left != 0) begin
            burst_left--;
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= it.op;
        i_s_axis_tdata  <= {it.mask, it.slot, it.payload, it.length, it.handle,
                            it.prio, it.source, it.code};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_results.push_back(table_apply(it));
    endtask

    // Stops offering words and waits until every result has come back.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_RUNNING) begin
            running_mirror = val[0];
        end else begin
            emergency_mirror = val;
        end
    endtask

    task automatic configure(input logic run, input logic [PRI_W-1:0] level);
        logic [2:0] junk;
        junk = 3'($urandom);
        drain();
        write_reg(CFG_RUNNING, {junk, run});
        write_reg(CFG_EMERGENCY, level);
    endtask

    // Field extremes, a zero code, gets while stopped and the clear operations.
    task automatic test_basic_ops();
        t_item it;
        send_item(control_item(OP_GET, 4'd0, 16'hFFFF));
        it         = post_item(8'h01, 16'h0000, 4'h0);
        it.handle  = '0;
        it.length  = '0;
        it.payload = '0;
        it.slot    = '0;
        it.mask    = '0;
        send_item(it);
        it         = post_item(8'hFF, 16'hFFFF, 4'hF);
        it.handle  = '1;
        it.length  = '1;
        it.payload = '1;
        it.slot    = '1;
        it.mask    = '1;
        send_item(it);
        send_item(post_item(8'h00, 16'hFFFF, 4'hF));
        send_item(control_item(OP_GET, 4'd0, 16'hFFFF));
        // Emergency level is still at its reset value here.
        drain();
        write_reg(CFG_RUNNING, 4'd1);
        send_item(control_item(OP_GET, 4'd0, 16'hFFFF));
        send_item(control_item(OP_GET, 4'd0, 16'h0000));
        send_item(control_item(OP_CLEAR, 4'd1, 16'h0000));
        send_item(control_item(OP_CLEAR, 4'd15, 16'h0000));
        send_item(control_item(OP_CLEAR_ALL, 4'd0, 16'h0000));
    endtask

    // Fills every slot at one priority, posts into the full table, checks a tie.
    task automatic test_full_table();
        for (int i = 0; i < SLOTS; i++) begin
            send_item(post_item(8'(i + 1), 16'h0001 | (16'h0001 << i), 4'h5));
        end
        send_item(post_item(8'hA5, 16'($urandom), 4'($urandom)));
        send_item(control_item(OP_GET, 4'd0, 16'h0001));
    endtask

    task automatic test_random_mix(input int count, input int post_pct, input int pri_top);
        repeat (count) send_item(random_item(post_pct, pri_top));
    endtask

    // The sink holds off for a long stretch while words keep coming.
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        gaps_on       = 1'b0;
        test_random_mix(40, 50, 15);
        gaps_on = 1'b1;
        drain();
    endtask

    // Result sink: a long hold on request, otherwise stall patterns that change.
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned phase_left;
        int unsigned mode;
        hold_left  = 0;
        phase_left = 0;
        mode       = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && hold_left == 0) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    mode       = $urandom_range(0, 3);
                    phase_left = $urandom_range(8, 64);
                end
                phase_left--;
                case (mode)
                    0: i_m_axis_tready <= 1'b1;
                    1: i_m_axis_tready <= 1'($urandom_range(0, 1));
                    2: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_axis_tready <= phase_left[2];
                endcase
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compares each accepted result word with the oldest expected one.
    always @(posedge i_clk) begin : result_check
        t_result want;
        t_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no operation waiting for it");
                mismatch_count++;
            end else begin
                want        = pending_results.pop_front();
                got.success = o_m_axis_tuser[0];
                got.found   = o_m_axis_tuser[1];
                got.slot    = o_m_axis_tdata[3:0];
                got.code    = o_m_axis_tdata[11:4];
                got.source  = o_m_axis_tdata[27:12];
                got.prio    = o_m_axis_tdata[31:28];
                got.handle  = o_m_axis_tdata[63:32];
                got.length  = o_m_axis_tdata[79:64];
                got.payload = o_m_axis_tdata[111:80];
                check_field("success", 32'(want.success), 32'(got.success));
                check_field("found", 32'(want.found), 32'(got.found));
                check_field("hit_slot", 32'(want.slot), 32'(got.slot));
                check_field("hit_code", 32'(want.code), 32'(got.code));
                check_field("hit_source", 32'(want.source), 32'(got.source));
                check_field("hit_priority", 32'(want.prio), 32'(got.prio));
                check_field("hit_handle", want.handle, got.handle);
                check_field("hit_length", 32'(want.length), 32'(got.length));
                check_field("hit_payload", want.payload, got.payload);
            end
        end
    end

    // Ends the run when nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= OP_POST;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_RUNNING;
        i_cfg_wdata     <= '0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_mirror[i] = '0;
        end
        running_mirror   = 1'b0;
        emergency_mirror = 4'hF;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_full_table();

        configure(1'b1, 4'd15);
        test_random_mix(250, 50, 15);
        configure(1'b1, 4'd0);
        test_random_mix(250, 45, 15);
        configure(1'b1, 4'd8);
        test_random_mix(250, 55, 3);
        configure(1'b0, 4'd15);
        test_random_mix(150, 50, 15);
        configure(1'b1, 4'd3);
        test_random_mix(250, 50, 7);
        configure(1'b1, 4'd15);
        test_random_mix(250, 35, 3);
        test_backpressure();
        configure(1'b1, 4'($urandom_range(0, 15)));
        test_random_mix(300, 50, 15);
        configure(1'b1, 4'd12);
        test_random_mix(250, 60, 15);

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/pet_pkg.sv
rtl/pet_slot_ram.sv
rtl/priority_event_table.sv
rtl/pet_checker.sv
verif/tb_priority_event_table.sv
